// ----- rtl/core/face_box_smoother_forehead_roi_top_macros.svh -----
// Assertion macros shared by the face box smoother RTL.
`ifndef FACE_BOX_SMOOTHER_FOREHEAD_ROI_TOP_MACROS_SVH
`define FACE_BOX_SMOOTHER_FOREHEAD_ROI_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, switched off while reset is asserted.
`define FBS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fbs assertion failed");
// Checked property that must also hold during reset.
`define FBS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("fbs assertion failed");
`else
`define FBS_ASSERT(lbl, clk, rst_n, prop)
`define FBS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/core/fbs_pkg.sv -----
// Shared types and constants for the face box smoother.
`timescale 1ns / 1ps
package fbs_pkg;

    localparam int BOX_W   = 9;
    localparam int SCALE_W = 4;
    localparam int COORD_W = 13;
    localparam int CORNERS = 4;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(7);
    localparam logic [COORD_W-1:0] COORD_MAX   = '1;

    localparam int WINDOW_DEFAULT      = 8;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Reciprocal constants for the forehead fractions. Each gives an exact
    // floor quotient over the full range of its numerator.
    localparam int          DIV10_SHIFT = 20;
    localparam int unsigned DIV10_MUL   = ((1 << DIV10_SHIFT) + 9) / 10;
    localparam int unsigned X3_MUL      = 3 * DIV10_MUL;
    localparam int unsigned X7_MUL      = 7 * DIV10_MUL;
    localparam int          X3_MUL_W    = $clog2(X3_MUL + 1);
    localparam int          X7_MUL_W    = $clog2(X7_MUL + 1);

    localparam int          DIV20_SHIFT = 18;
    localparam int unsigned DIV20_MUL   = ((1 << DIV20_SHIFT) + 19) / 20;
    localparam int          DIV20_MUL_W = $clog2(DIV20_MUL + 1);

    localparam int          DIV5_SHIFT  = 16;
    localparam int unsigned DIV5_MUL    = ((1 << DIV5_SHIFT) + 4) / 5;
    localparam int          DIV5_MUL_W  = $clog2(DIV5_MUL + 1);

    typedef logic [CORNERS-1:0][COORD_W-1:0] corners_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fbs_q_stat_t;

endpackage

// ----- rtl/core/fbs_box_if.sv -----
// Input channel carrying one detected face box per word.
`timescale 1ns / 1ps
interface fbs_box_if;
    import fbs_pkg::*;

    logic               valid;
    logic               ready;
    logic [BOX_W-1:0]   box_x;
    logic [BOX_W-1:0]   box_y;
    logic [BOX_W-1:0]   box_w;
    logic [BOX_W-1:0]   box_h;

    modport source (output valid, output box_x, output box_y, output box_w,
                     output box_h, input ready);
    modport sink   (input valid, input box_x, input box_y, input box_w,
                    input box_h, output ready);
endinterface

// ----- rtl/core/fbs_roi_if.sv -----
// Output channel carrying the smoothed face box and forehead region.
`timescale 1ns / 1ps
interface fbs_roi_if;
    import fbs_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] face_x;
    logic [COORD_W-1:0] face_y;
    logic [COORD_W-1:0] face_w;
    logic [COORD_W-1:0] face_h;
    logic [COORD_W-1:0] forehead_x;
    logic [COORD_W-1:0] forehead_y;
    logic [COORD_W-1:0] forehead_w;
    logic [COORD_W-1:0] forehead_h;
    logic               region_valid;
    logic               was_averaged;

    modport source (output valid, output face_x, output face_y, output face_w,
                     output face_h, output forehead_x, output forehead_y,
                     output forehead_w, output forehead_h, output region_valid,
                     output was_averaged, input ready);
    modport sink   (input valid, input face_x, input face_y, input face_w,
                    input face_h, input forehead_x, input forehead_y,
                    input forehead_w, input forehead_h, input region_valid,
                    input was_averaged, output ready);
endinterface

// ----- rtl/core/face_box_smoother_forehead_roi_top.sv -----
// Top level of the face box smoother with forehead region.
`timescale 1ns / 1ps
// Usage:
// box carries one detected face box per word (box_x, box_y, box_w, box_h in
// detector pixels); roi returns one word per box with the full-resolution
// face box, the forehead region, region_valid and was_averaged.
// cfg_we with cfg_wdata writes the upscale factor; write it only while idle.
// A word accepted on box passes the input stage, the queue and the back
// pipeline to roi; with roi not stalled, one word is accepted and one
// delivered every cycle. Back pipeline: reciprocal multiply for the mean,
// face size subtraction, forehead reciprocal multiplies, output register.
// The first WINDOW boxes pass through; after that each result is the mean
// of the previous WINDOW boxes.
// Reset clears the window, the sums and the queue and sets the factor to 7.
// When roi stalls, the back pipeline holds, the front end fills a four-word
// queue, and box.ready falls once the queue and the input stage are full.
module face_box_smoother_forehead_roi_top #(
    parameter int WINDOW      = fbs_pkg::WINDOW_DEFAULT,
    parameter int QUEUE_DEPTH = fbs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fbs_box_if.sink                     box,
    fbs_roi_if.source                   roi,
    input  logic                        cfg_we,
    input  logic [fbs_pkg::SCALE_W-1:0] cfg_wdata
);
    import fbs_pkg::*;

    localparam int SUM_W   = COORD_W + $clog2(WINDOW);
    localparam int ENTRY_W = CORNERS * SUM_W + 1;

    logic [SCALE_W-1:0] scale_reg;
    fbs_q_stat_t        q_stat;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (cfg_we)
            scale_reg <= cfg_wdata;
    end

    fbs_front #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .box       (box),
        .scale     (scale_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    fbs_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    fbs_back #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (head),
        .pop    (pop),
        .roi    (roi)
    );

endmodule

// ----- rtl/core/fbs_front.sv -----
// Front end: scales incoming boxes and keeps the window of corners and sums.
`timescale 1ns / 1ps
`include "face_box_smoother_forehead_roi_top_macros.svh"
module fbs_front #(
    parameter int WINDOW = fbs_pkg::WINDOW_DEFAULT,
    parameter int SUM_W  = fbs_pkg::COORD_W + $clog2(fbs_pkg::WINDOW_DEFAULT)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    fbs_box_if.sink                              box,
    input  logic [fbs_pkg::SCALE_W-1:0]          scale,
    input  fbs_pkg::fbs_q_stat_t                 q_stat,
    output logic                                 push,
    output logic [fbs_pkg::CORNERS*SUM_W:0]      push_data
);
    import fbs_pkg::*;

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int PROD_W = BOX_W + 1 + SCALE_W;

    typedef logic [CORNERS-1:0][SUM_W-1:0] sums_t;

    function automatic logic [COORD_W-1:0] scale_corner(
        input logic [BOX_W:0]     v,
        input logic [SCALE_W-1:0] s
    );
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(v) * PROD_W'(s);
        return (prod > PROD_W'(COORD_MAX)) ? COORD_MAX : prod[COORD_W-1:0];
    endfunction

    logic              accept;
    logic              full;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    corners_t          cur_reg;
    corners_t          cur_next;
    corners_t          line_reg [WINDOW];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    sums_t             sum_reg;
    sums_t             sum_next;
    sums_t             out_v;

    assign full      = (fill_reg == FILL_W'(WINDOW));
    assign push      = s1_valid_reg && !q_stat.full;
    assign box.ready = !s1_valid_reg || push;
    assign accept    = box.valid && box.ready;

    always_comb
    begin
        cur_next[0] = scale_corner({1'b0, box.box_x}, scale);
        cur_next[1] = scale_corner({1'b0, box.box_y}, scale);
        cur_next[2] = scale_corner({1'b0, box.box_x} + {1'b0, box.box_w}, scale);
        cur_next[3] = scale_corner({1'b0, box.box_y} + {1'b0, box.box_h}, scale);

        if (accept)
            s1_valid_next = 1'b1;
        else if (push)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // Once the window is full the oldest set sits at the tail of the line
    // and leaves the sums as the current set enters.
    always_comb
    begin
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (push)
        begin
            if (!full)
                fill_next = fill_reg + 1'b1;
            for (int k = 0; k < CORNERS; k++)
            begin
                sum_next[k] = sum_reg[k] + SUM_W'(cur_reg[k])
                              - (full ? SUM_W'(line_reg[WINDOW-1][k]) : '0);
            end
        end
        for (int k = 0; k < CORNERS; k++)
            out_v[k] = full ? sum_reg[k] : SUM_W'(cur_reg[k]);
    end

    assign push_data = {full, out_v};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fill_reg     <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            fill_reg     <= fill_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cur_reg <= cur_next;
        if (push)
        begin
            line_reg[0] <= cur_reg;
            for (int i = 1; i < WINDOW; i++)
                line_reg[i] <= line_reg[i-1];
        end
    end

    `FBS_ASSERT(a_fill_counts_up, clk, rst_n, push && !full |=> fill_reg == $past(fill_reg) + 1'b1)
    `FBS_ASSERT(a_full_stays, clk, rst_n, full |=> full)

endmodule

// ----- rtl/core/fbs_queue.sv -----
// Short queue decoupling the front end from the back end.
`timescale 1ns / 1ps
`include "face_box_smoother_forehead_roi_top_macros.svh"
module fbs_queue #(
    parameter int DEPTH  = fbs_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int DATA_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_W-1:0]    push_data,
    input  logic                 pop,
    output logic [DATA_W-1:0]    head,
    output fbs_pkg::fbs_q_stat_t q_stat
);
    import fbs_pkg::*;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0]  entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == COUNT_W'(DEPTH));
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `FBS_ASSERT(a_q_count_bound, clk, rst_n, count_reg <= COUNT_W'(DEPTH))
    `FBS_ASSERT(a_q_no_underflow, clk, rst_n, pop |-> !q_stat.empty)

endmodule

// ----- rtl/core/fbs_back.sv -----
// Back end: window mean, face size and forehead region, with output register.
`timescale 1ns / 1ps
`include "face_box_smoother_forehead_roi_top_macros.svh"
module fbs_back #(
    parameter int WINDOW = fbs_pkg::WINDOW_DEFAULT,
    parameter int SUM_W  = fbs_pkg::COORD_W + $clog2(fbs_pkg::WINDOW_DEFAULT)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fbs_pkg::fbs_q_stat_t             q_stat,
    input  logic [fbs_pkg::CORNERS*SUM_W:0]  head,
    output logic                             pop,
    fbs_roi_if.source                        roi
);
    import fbs_pkg::*;

    // Mean by multiplication with a rounded-up reciprocal of the window size;
    // exact for every sum the window can hold.
    localparam int              DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam longint unsigned MEAN_MUL  =
        ((64'd1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int              MUL_W     = SUM_W + 1;

    typedef logic [CORNERS-1:0][SUM_W-1:0] sums_t;

    logic                       back_en;

    logic                       b1_valid_reg;
    logic                       b1_avg_reg;
    sums_t                      b1_v_reg;
    logic [SUM_W+MUL_W-1:0]     mean_prod [CORNERS];
    corners_t                   res_next;

    logic                       b2_valid_reg;
    logic                       b2_avg_reg;
    corners_t                   res_reg;
    logic [COORD_W-1:0]         fw_next;
    logic [COORD_W-1:0]         fh_next;

    logic                       b3_valid_reg;
    logic                       b3_avg_reg;
    logic                       b3_rv_reg;
    logic [COORD_W-1:0]         b3_x_reg;
    logic [COORD_W-1:0]         b3_y_reg;
    logic [COORD_W-1:0]         b3_fw_reg;
    logic [COORD_W-1:0]         b3_fh_reg;
    logic [COORD_W+X3_MUL_W-1:0]    p3;
    logic [COORD_W+X7_MUL_W-1:0]    p7;
    logic [COORD_W+DIV20_MUL_W-1:0] p20;
    logic [COORD_W+DIV5_MUL_W-1:0]  p5;

    logic                       b4_valid_reg;
    logic                       b4_avg_reg;
    logic                       b4_rv_reg;
    logic [COORD_W-1:0]         b4_x_reg;
    logic [COORD_W-1:0]         b4_y_reg;
    logic [COORD_W-1:0]         b4_fw_reg;
    logic [COORD_W-1:0]         b4_fh_reg;
    logic [COORD_W-1:0]         q3_reg;
    logic [COORD_W-1:0]         q7_reg;
    logic [COORD_W-1:0]         q20_reg;
    logic [COORD_W-1:0]         q5_reg;

    logic                       out_valid_reg;
    logic [COORD_W-1:0]         face_x_reg;
    logic [COORD_W-1:0]         face_y_reg;
    logic [COORD_W-1:0]         face_w_reg;
    logic [COORD_W-1:0]         face_h_reg;
    logic [COORD_W-1:0]         fore_x_reg;
    logic [COORD_W-1:0]         fore_y_reg;
    logic [COORD_W-1:0]         fore_w_reg;
    logic [COORD_W-1:0]         fore_h_reg;
    logic                       rv_reg;
    logic                       avg_reg;

    // The whole back pipeline advances together whenever the output word
    // is free or being taken.
    assign back_en = !out_valid_reg || roi.ready;
    assign pop     = back_en && !q_stat.empty;

    always_comb
    begin
        for (int k = 0; k < CORNERS; k++)
        begin
            mean_prod[k] = b1_v_reg[k] * MUL_W'(MEAN_MUL);
            res_next[k]  = b1_avg_reg ? COORD_W'(mean_prod[k] >> DIV_SHIFT)
                                      : b1_v_reg[k][COORD_W-1:0];
        end
        fw_next = (res_reg[2] >= res_reg[0]) ? res_reg[2] - res_reg[0] : '0;
        fh_next = (res_reg[3] >= res_reg[1]) ? res_reg[3] - res_reg[1] : '0;
        p3  = b3_fw_reg * X3_MUL_W'(X3_MUL);
        p7  = b3_fw_reg * X7_MUL_W'(X7_MUL);
        p20 = b3_fh_reg * DIV20_MUL_W'(DIV20_MUL);
        p5  = b3_fh_reg * DIV5_MUL_W'(DIV5_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (back_en)
        begin
            b1_valid_reg  <= pop;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            b4_valid_reg  <= b3_valid_reg;
            out_valid_reg <= b4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            b1_avg_reg <= head[CORNERS*SUM_W];
            b1_v_reg   <= head[CORNERS*SUM_W-1:0];

            b2_avg_reg <= b1_avg_reg;
            res_reg    <= res_next;

            b3_avg_reg <= b2_avg_reg;
            b3_x_reg   <= res_reg[0];
            b3_y_reg   <= res_reg[1];
            b3_fw_reg  <= fw_next;
            b3_fh_reg  <= fh_next;
            b3_rv_reg  <= (fw_next != '0) && (fh_next != '0);

            b4_avg_reg <= b3_avg_reg;
            b4_rv_reg  <= b3_rv_reg;
            b4_x_reg   <= b3_x_reg;
            b4_y_reg   <= b3_y_reg;
            b4_fw_reg  <= b3_fw_reg;
            b4_fh_reg  <= b3_fh_reg;
            q3_reg     <= COORD_W'(p3 >> DIV10_SHIFT);
            q7_reg     <= COORD_W'(p7 >> DIV10_SHIFT);
            q20_reg    <= COORD_W'(p20 >> DIV20_SHIFT);
            q5_reg     <= COORD_W'(p5 >> DIV5_SHIFT);

            // The forehead never passes the right or bottom edge, so these
            // sums stay within the coordinate range.
            face_x_reg <= b4_x_reg;
            face_y_reg <= b4_y_reg;
            face_w_reg <= b4_fw_reg;
            face_h_reg <= b4_fh_reg;
            fore_x_reg <= b4_rv_reg ? b4_x_reg + q3_reg : '0;
            fore_y_reg <= b4_rv_reg ? b4_y_reg + q20_reg : '0;
            fore_w_reg <= b4_rv_reg ? q7_reg - q3_reg : '0;
            fore_h_reg <= b4_rv_reg ? q5_reg - q20_reg : '0;
            rv_reg     <= b4_rv_reg;
            avg_reg    <= b4_avg_reg;
        end
    end

    assign roi.valid        = out_valid_reg;
    assign roi.face_x       = face_x_reg;
    assign roi.face_y       = face_y_reg;
    assign roi.face_w       = face_w_reg;
    assign roi.face_h       = face_h_reg;
    assign roi.forehead_x   = fore_x_reg;
    assign roi.forehead_y   = fore_y_reg;
    assign roi.forehead_w   = fore_w_reg;
    assign roi.forehead_h   = fore_h_reg;
    assign roi.region_valid = rv_reg;
    assign roi.was_averaged = avg_reg;

    `FBS_ASSERT(a_empty_region_zero, clk, rst_n, roi.valid && !roi.region_valid |-> roi.forehead_w == '0 && roi.forehead_h == '0 && roi.forehead_x == '0)

endmodule
